// ===== rtl/coordinated_servo_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// Coordinated servo interpolator assertion macros
// Shared property macros for the concurrent checks of the interpolator.
// ----------------------------------------------------------------------------
`ifndef COORDINATED_SERVO_INTERPOLATOR_DEFINES_SVH
`define COORDINATED_SERVO_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/csi_pkg.sv =====
// ----------------------------------------------------------------------------
// Coordinated servo interpolator package
// Widths, command codes, controller types and angle helpers.
// ----------------------------------------------------------------------------
package csi_pkg;

    localparam int MAX_SERVOS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_SERVOS);
    localparam int SERVO_W    = 4;
    localparam int CNT_W      = 4;
    localparam int ANG_W      = 11 + FRAC_BITS;
    localparam int DIFF_W     = ANG_W + 1;
    localparam int INC_W      = FRAC_BITS + 2;
    localparam int STEPS_W    = 10;
    localparam int TICK_W     = 16;
    localparam int ADEG_W     = ANG_W - FRAC_BITS;
    localparam int NUM_W      = ADEG_W + 1;
    localparam int PDIFF_W    = 13;
    localparam int PROD_W     = 25;
    localparam int QUO_W      = 22;
    localparam int PSUM_W     = QUO_W + 2;
    localparam int PULSE_W    = 12;
    localparam int DVD_W      = ANG_W + FRAC_BITS;
    localparam int DVS_W      = ANG_W;
    localparam int ITER_W     = $clog2(DVD_W + 1);

    localparam longint ANG_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [ANG_W-1:0] ANG_LO = ANG_W'(-512 * ANG_ONE);
    localparam logic signed [ANG_W-1:0] ANG_HI = ANG_W'(511 * ANG_ONE);
    localparam logic [PULSE_W-1:0] PULSE_TOP = {PULSE_W{1'b1}};

    typedef enum logic [2:0] {
        FN_STAGE_ABS = 3'd0,
        FN_STAGE_REL = 3'd1,
        FN_START     = 3'd2,
        FN_TICK      = 3'd3,
        FN_SET_NOW   = 3'd4,
        FN_SET_HOME  = 3'd5,
        FN_HOME_NOW  = 3'd6,
        FN_HOME_SYNC = 3'd7
    } func_t;

    localparam logic [2:0] CFG_ANGLE_MIN     = 3'd0;
    localparam logic [2:0] CFG_ANGLE_MAX     = 3'd1;
    localparam logic [2:0] CFG_PULSE_MIN     = 3'd2;
    localparam logic [2:0] CFG_PULSE_MAX     = 3'd3;
    localparam logic [2:0] CFG_STEP_PERIOD   = 3'd4;
    localparam logic [2:0] CFG_ACTIVE_SERVOS = 3'd5;

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b0000_0000_0001,
        ST_DECODE     = 12'b0000_0000_0010,
        ST_SCAN       = 12'b0000_0000_0100,
        ST_SCAN_END   = 12'b0000_0000_1000,
        ST_EQ         = 12'b0000_0001_0000,
        ST_DIV_INC    = 12'b0000_0010_0000,
        ST_WAIT_INC   = 12'b0000_0100_0000,
        ST_LOAD       = 12'b0000_1000_0000,
        ST_MUL        = 12'b0001_0000_0000,
        ST_DIV_PULSE  = 12'b0010_0000_0000,
        ST_WAIT_PULSE = 12'b0100_0000_0000,
        ST_OUT        = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic capture;
        logic single_wr;
        logic tick_inc;
        logic tick_fire;
        logic ptr_clr;
        logic ptr_inc;
        logic dmax_clr;
        logic scan_en;
        logic eq_wr;
        logic div_start_inc;
        logic div_start_pulse;
        logic inc_wr;
        logic move_begin;
        logic move_end;
        logic pulse_load;
        logic mul_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  idx_ok;
        logic  moving;
        logic  fire;
        logic  n_zero;
        logic  ptr_last;
        logic  dmax_zero;
        logic  step_done;
        logic  div_done;
        logic  out_taken;
    } dp_status_t;

    function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [DIFF_W-1:0] v);
        if (v < DIFF_W'(ANG_LO)) begin
            return ANG_LO;
        end else if (v > DIFF_W'(ANG_HI)) begin
            return ANG_HI;
        end
        return ANG_W'(v);
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        if (v > CNT_W'(MAX_SERVOS)) begin
            return CNT_W'(MAX_SERVOS);
        end
        return v;
    endfunction

endpackage

// ===== rtl/coordinated_servo_interpolator.sv =====
// ----------------------------------------------------------------------------
// Coordinated servo interpolator
// Synchronised multi-axis servo moves with linear pulse-width mapping.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel, one beat each; pulse widths leave on the
// m_ channel, one beat per servo, with last_of_run marking the final beat of
// a step or command and move_done marking every beat of the closing step.
// Registers are written through the cfg_ channel, which is always ready.
// Commands without results return to idle from the decode state, as does a
// tick that does not fire. Each pulse beat passes through load, multiply,
// the shared divider and the output register. A start or home sync works out
// each servo's increment in that divider, one servo after another.
// One command is in flight at a time: s_ready is low until its last beat has
// been taken. A stalled receiver simply holds the block in its output state.
// Reset clears all angles and increments and restores the register defaults.
// ----------------------------------------------------------------------------
`include "coordinated_servo_interpolator_defines.svh"

module coordinated_servo_interpolator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_func,
    input  logic [3:0]                    s_servo_index,
    input  logic signed [8:0]             s_angle_value,
    input  logic [3:0]                    s_move_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_out_servo,
    output logic [csi_pkg::PULSE_W-1:0]   m_pulse_width,
    output logic                          m_last_of_run,
    output logic                          m_move_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import csi_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    csi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csi_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_func        (s_func),
        .s_servo_index (s_servo_index),
        .s_angle_value (s_angle_value),
        .s_move_count  (s_move_count),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_servo   (m_out_servo),
        .m_pulse_width (m_pulse_width),
        .m_last_of_run (m_last_of_run),
        .m_move_done   (m_move_done)
    );

    `CSI_ASSERT_SAME(a_no_accept_while_beat, s_ready, !m_valid, "command taken with beat pending")
    `CSI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_valid, "pending beat overwritten")
    `CSI_ASSERT_NEXT(a_div_busy, cmd.div_start_inc || cmd.div_start_pulse, !s_ready, "idle in division")

endmodule

// ===== rtl/csi_div.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csi_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [csi_pkg::DVD_W-1:0]      dividend,
    input  logic [csi_pkg::DVS_W-1:0]      divisor,
    input  logic [csi_pkg::ITER_W-1:0]     iters,
    output logic                           done,
    output logic [csi_pkg::QUO_W-1:0]      quotient
);
    import csi_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DVS_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iters;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], ge};
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/csi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences commands, move set-up passes and per-servo pulse generation.
// ----------------------------------------------------------------------------
module csi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csi_pkg::dp_status_t   sts,
    output csi_pkg::ctrl_cmd_t    cmd
);
    import csi_pkg::*;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next  = ST_IDLE;
                cmd.ptr_clr = 1'b1;
                if (sts.func == FN_SET_HOME) begin
                    cmd.single_wr = 1'b1;
                end else if (sts.func == FN_TICK) begin
                    if (sts.moving && !sts.fire) begin
                        cmd.tick_inc = 1'b1;
                    end else if (sts.moving) begin
                        cmd.tick_fire = 1'b1;
                        state_next    = ST_LOAD;
                    end
                end else if (!sts.moving) begin
                    case (sts.func)
                        FN_STAGE_ABS, FN_STAGE_REL: begin
                            cmd.single_wr = 1'b1;
                        end
                        FN_SET_NOW: begin
                            if (sts.idx_ok) begin
                                state_next = ST_LOAD;
                            end
                        end
                        FN_HOME_NOW: begin
                            if (!sts.n_zero) begin
                                state_next = ST_LOAD;
                            end
                        end
                        FN_START, FN_HOME_SYNC: begin
                            if (!sts.n_zero) begin
                                cmd.dmax_clr = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.ptr_last) begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_SCAN_END;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SCAN_END: begin
                state_next = sts.dmax_zero ? ST_EQ : ST_DIV_INC;
            end
            ST_EQ: begin
                cmd.eq_wr = 1'b1;
                if (sts.ptr_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_DIV_INC: begin
                cmd.div_start_inc = 1'b1;
                state_next        = ST_WAIT_INC;
            end
            ST_WAIT_INC: begin
                if (sts.div_done) begin
                    cmd.inc_wr = 1'b1;
                    if (sts.ptr_last) begin
                        cmd.move_begin = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_DIV_INC;
                    end
                end
            end
            ST_LOAD: begin
                cmd.pulse_load = 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIV_PULSE;
            end
            ST_DIV_PULSE: begin
                cmd.div_start_pulse = 1'b1;
                state_next          = ST_WAIT_PULSE;
            end
            ST_WAIT_PULSE: begin
                if (sts.div_done) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_taken) begin
                    if (sts.func == FN_SET_NOW || sts.ptr_last) begin
                        cmd.move_end = (sts.func == FN_TICK) && sts.step_done;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/csi_dp.sv =====
// ----------------------------------------------------------------------------
// Interpolator datapath
// Servo angle stores, move set-up arithmetic, pulse mapping and output beat.
// ----------------------------------------------------------------------------
module csi_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csi_pkg::ctrl_cmd_t            cmd,
    output csi_pkg::dp_status_t           sts,
    input  logic [2:0]                    s_func,
    input  logic [3:0]                    s_servo_index,
    input  logic signed [8:0]             s_angle_value,
    input  logic [3:0]                    s_move_count,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_out_servo,
    output logic [csi_pkg::PULSE_W-1:0]   m_pulse_width,
    output logic                          m_last_of_run,
    output logic                          m_move_done
);
    import csi_pkg::*;

    logic [7:0]         angle_min_reg, angle_max_reg;
    logic [11:0]        pulse_min_reg, pulse_max_reg;
    logic [15:0]        step_period_reg;
    logic [3:0]         active_reg;

    func_t              func_reg;
    logic [3:0]         idx_reg;
    logic signed [8:0]  ang_reg;
    logic [CNT_W-1:0]   n_reg, n_next;

    logic signed [ANG_W-1:0] cur_reg [MAX_SERVOS];
    logic signed [ANG_W-1:0] wrk_reg [MAX_SERVOS];
    logic signed [ANG_W-1:0] tgt_reg [MAX_SERVOS];
    logic signed [8:0]       home_reg [MAX_SERVOS];
    logic signed [INC_W-1:0] inc_reg [MAX_SERVOS];

    logic [STEPS_W-1:0] steps_reg;
    logic [CNT_W-1:0]   move_servos_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic               moving_reg;
    logic               step_done_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [DVS_W-1:0]   dmax_reg;

    logic signed [ANG_W-1:0]  q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pneg_reg;
    logic [3:0]               servo_reg;
    logic                     last_reg, done_reg;

    logic                     m_valid_reg;
    logic [3:0]               m_servo_reg;
    logic [PULSE_W-1:0]       m_pulse_reg;
    logic                     m_last_reg, m_done_reg;

    logic                     use_idx, idx_ok;
    logic [IDX_W-1:0]         addr;
    logic signed [ANG_W-1:0]  cur_rd, wrk_rd, tgt_rd, home_q, ang_q, tgt_eff;
    logic signed [ANG_W-1:0]  rel_sum, step_sum;
    logic signed [INC_W-1:0]  inc_rd;
    logic signed [DIFF_W-1:0] diff;
    logic [DVS_W-1:0]         abs_d;
    logic [DVS_W:0]           ceil_sum;

    logic signed [ADEG_W-1:0] a_deg;
    logic signed [NUM_W-1:0]  num;
    logic signed [PDIFF_W-1:0] pdiff;
    logic signed [8:0]        adiff;
    logic [7:0]               amag;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_mag;
    logic signed [PSUM_W-1:0] psum;
    logic [PULSE_W-1:0]       pulse;
    logic signed [INC_W-1:0]  inc_val;

    logic                     div_start, div_done;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic [ITER_W-1:0]        div_iters;
    logic [QUO_W-1:0]         quo;

    assign use_idx = (func_reg == FN_STAGE_ABS) || (func_reg == FN_STAGE_REL) ||
                     (func_reg == FN_SET_NOW)   || (func_reg == FN_SET_HOME);
    assign idx_ok  = idx_reg < 4'(MAX_SERVOS);
    assign addr    = use_idx ? idx_reg[IDX_W-1:0] : ptr_reg;

    assign cur_rd  = cur_reg[addr];
    assign wrk_rd  = wrk_reg[addr];
    assign tgt_rd  = tgt_reg[addr];
    assign inc_rd  = inc_reg[addr];
    assign home_q  = ANG_W'(home_reg[addr]) <<< FRAC_BITS;
    assign ang_q   = ANG_W'(ang_reg) <<< FRAC_BITS;
    assign tgt_eff = (func_reg == FN_HOME_SYNC) ? home_q : tgt_rd;

    assign diff     = DIFF_W'(tgt_eff) - DIFF_W'(cur_rd);
    assign abs_d    = diff[DIFF_W-1] ? DVS_W'(-diff) : DVS_W'(diff);
    assign rel_sum  = sat_angle(DIFF_W'(cur_rd) + DIFF_W'(ang_q));
    assign step_sum = sat_angle(DIFF_W'(wrk_rd) + DIFF_W'(inc_rd));
    assign ceil_sum = {1'b0, dmax_reg} + (DVS_W+1)'(ANG_ONE - 1);
    assign inc_val  = diff[DIFF_W-1] ? -INC_W'(quo) : INC_W'(quo);

    always_comb begin
        case (func_t'(s_func))
            FN_START:                 n_next = clamp_count(s_move_count);
            FN_TICK:                  n_next = move_servos_reg;
            FN_HOME_NOW, FN_HOME_SYNC: n_next = clamp_count(active_reg);
            default:                  n_next = CNT_W'(1);
        endcase
    end

    // Pulse mapping: the angle is truncated toward zero to whole degrees.
    assign a_deg = ADEG_W'(q_reg >>> FRAC_BITS) +
                   ADEG_W'((q_reg < 0) && (q_reg[FRAC_BITS-1:0] != '0));
    assign num   = NUM_W'(a_deg) - NUM_W'($signed({1'b0, angle_min_reg}));
    assign pdiff = PDIFF_W'($signed({1'b0, pulse_max_reg})) -
                   PDIFF_W'($signed({1'b0, pulse_min_reg}));
    assign adiff = $signed({1'b0, angle_max_reg}) - $signed({1'b0, angle_min_reg});
    assign amag  = adiff[8] ? 8'(-adiff) : 8'(adiff);
    assign prod  = PROD_W'(num) * PROD_W'(pdiff);
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    always_comb begin
        if (adiff == '0) begin
            psum = PSUM_W'($signed({1'b0, pulse_min_reg}));
        end else begin
            psum = (pneg_reg ? -PSUM_W'($signed({2'b0, quo})) : PSUM_W'($signed({2'b0, quo})))
                   + PSUM_W'($signed({1'b0, pulse_min_reg}));
        end
        if (psum < 0) begin
            pulse = '0;
        end else if (psum > PSUM_W'(PULSE_TOP)) begin
            pulse = PULSE_TOP;
        end else begin
            pulse = PULSE_W'(psum);
        end
    end

    assign div_start = cmd.div_start_inc || cmd.div_start_pulse;
    assign div_dvd   = cmd.div_start_pulse ? {prod_mag[QUO_W-1:0], (DVD_W-QUO_W)'(0)}
                                           : {abs_d, FRAC_BITS'(0)};
    assign div_dvs   = cmd.div_start_pulse ? DVS_W'(amag) : dmax_reg;
    assign div_iters = cmd.div_start_pulse ? ITER_W'(QUO_W) : ITER_W'(DVD_W);

    csi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_min_reg   <= 8'd0;
            angle_max_reg   <= 8'd172;
            pulse_min_reg   <= 12'd550;
            pulse_max_reg   <= 12'd2400;
            step_period_reg <= 16'd10;
            active_reg      <= 4'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ANGLE_MIN:     angle_min_reg   <= cfg_data[7:0];
                CFG_ANGLE_MAX:     angle_max_reg   <= cfg_data[7:0];
                CFG_PULSE_MIN:     pulse_min_reg   <= cfg_data[11:0];
                CFG_PULSE_MAX:     pulse_max_reg   <= cfg_data[11:0];
                CFG_STEP_PERIOD:   step_period_reg <= cfg_data;
                CFG_ACTIVE_SERVOS: active_reg      <= cfg_data[3:0];
                default:           active_reg      <= active_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SERVOS; i++) begin
                cur_reg[i]  <= '0;
                wrk_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                home_reg[i] <= '0;
                inc_reg[i]  <= '0;
            end
            steps_reg       <= '0;
            move_servos_reg <= '0;
            tick_reg        <= '0;
            moving_reg      <= 1'b0;
            step_done_reg   <= 1'b0;
            ptr_reg         <= '0;
            dmax_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.ptr_clr) begin
                ptr_reg <= '0;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
            if (cmd.single_wr && idx_ok) begin
                case (func_reg)
                    FN_STAGE_ABS: tgt_reg[addr]  <= ang_q;
                    FN_STAGE_REL: tgt_reg[addr]  <= rel_sum;
                    FN_SET_HOME:  home_reg[addr] <= ang_reg;
                    default:      tgt_reg[addr]  <= tgt_rd;
                endcase
            end
            if (cmd.dmax_clr) begin
                dmax_reg <= '0;
            end
            if (cmd.scan_en) begin
                if (func_reg == FN_HOME_SYNC) begin
                    tgt_reg[addr] <= home_q;
                end
                if (abs_d > dmax_reg) begin
                    dmax_reg <= abs_d;
                end
            end
            if (cmd.eq_wr) begin
                cur_reg[addr] <= tgt_rd;
                wrk_reg[addr] <= tgt_rd;
            end
            if (cmd.inc_wr) begin
                inc_reg[addr] <= inc_val;
                wrk_reg[addr] <= cur_rd;
            end
            if (cmd.move_begin) begin
                steps_reg       <= ceil_sum[FRAC_BITS +: STEPS_W];
                move_servos_reg <= n_reg;
                tick_reg        <= '0;
                moving_reg      <= 1'b1;
            end
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + TICK_W'(1);
            end
            if (cmd.tick_fire) begin
                tick_reg      <= '0;
                steps_reg     <= (steps_reg != '0) ? steps_reg - STEPS_W'(1) : steps_reg;
                step_done_reg <= steps_reg <= STEPS_W'(1);
            end
            if (cmd.pulse_load) begin
                case (func_reg)
                    FN_TICK: begin
                        if (step_done_reg) begin
                            cur_reg[addr] <= tgt_rd;
                            wrk_reg[addr] <= tgt_rd;
                        end else begin
                            wrk_reg[addr] <= step_sum;
                        end
                    end
                    FN_SET_NOW: begin
                        cur_reg[addr] <= ang_q;
                    end
                    FN_HOME_NOW: begin
                        cur_reg[addr] <= home_q;
                        wrk_reg[addr] <= home_q;
                    end
                    default: begin
                        cur_reg[addr] <= cur_rd;
                    end
                endcase
            end
            if (cmd.move_end) begin
                moving_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func_t'(s_func);
            idx_reg  <= s_servo_index;
            ang_reg  <= s_angle_value;
            n_reg    <= n_next;
        end
        if (cmd.pulse_load) begin
            case (func_reg)
                FN_TICK:    q_reg <= step_sum;
                FN_SET_NOW: q_reg <= ang_q;
                default:    q_reg <= home_q;
            endcase
            servo_reg <= 4'(addr);
            last_reg  <= (func_reg == FN_SET_NOW) || sts.ptr_last;
            done_reg  <= (func_reg == FN_TICK) && step_done_reg;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod;
            pneg_reg <= prod[PROD_W-1] ^ adiff[8];
        end
        if (cmd.out_load) begin
            m_servo_reg <= servo_reg;
            m_pulse_reg <= pulse;
            m_last_reg  <= last_reg;
            m_done_reg  <= done_reg;
        end
    end

    always_comb begin
        sts.func      = func_reg;
        sts.idx_ok    = idx_ok;
        sts.moving    = moving_reg;
        sts.fire      = (step_period_reg == '0) ||
                        ({1'b0, tick_reg} + 17'd1 >= {1'b0, step_period_reg});
        sts.n_zero    = (n_reg == '0);
        sts.ptr_last  = ({1'b0, ptr_reg} + (IDX_W+1)'(1)) == (IDX_W+1)'(n_reg);
        sts.dmax_zero = (dmax_reg == '0);
        sts.step_done = step_done_reg;
        sts.div_done  = div_done;
        sts.out_taken = m_valid_reg && m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_servo   = m_servo_reg;
    assign m_pulse_width = m_pulse_reg;
    assign m_last_of_run = m_last_reg;
    assign m_move_done   = m_done_reg;

endmodule
